// ===== hw/rtl/dlrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrs_pkg: shared types and constants of the dense layer
// Item formats, command format between front and back, codes, exp table.
// ----------------------------------------------------------------------------
`default_nettype none

package dlrs_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_ELEM   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_BIAS = 2'd1;

  // Activation modes; codes above softmax are unsupported.
  localparam logic [1:0] MODE_RELU    = 2'd0;
  localparam logic [1:0] MODE_SOFTMAX = 2'd1;

  localparam int ACC_W     = 40;
  localparam int EXP_DEPTH = 256;
  localparam int EXP_LD    = $clog2(EXP_DEPTH);
  localparam int EXP_W     = 31;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         row_index;
    logic [3:0]         node_index;
    logic signed [15:0] value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_node;
    logic signed [15:0] out_value;
    logic               out_last;
    logic               status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_ELEM   = 2'd2
  } cmd_kind_t;

  // Classified command; for an element, row carries the input position.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [9:0]         row;
    logic [3:0]         node;
    logic signed [15:0] value;
    logic               last;
    logic               pos_ok;
  } cmd_t;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_DEPTH];

  // exp(-i/16) in Q.30, built by repeated multiplication with rounding.
  function automatic exp_tab_t exp_tab_init();
    exp_tab_t        t;
    longint unsigned v;
    v = 64'd1 << 30;
    t[0] = EXP_W'(v);
    for (int i = 1; i < EXP_DEPTH; i++) begin
      v = (v * 64'd1008687096 + (64'd1 << 29)) >> 30;
      t[i] = EXP_W'(v);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_init();

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] x);
    logic signed [ACC_W-1:0] r;
    if (x[ACC_W] != x[ACC_W-1]) begin
      r = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dlrs_fifo.sv =====
// ----------------------------------------------------------------------------
// dlrs_fifo: command queue between front and back
// Four entries; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrs_fifo (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  dlrs_pkg::cmd_t   push_cmd,
  output logic             full,
  input  wire              pop,
  output dlrs_pkg::cmd_t   pop_cmd,
  output logic             empty
);
  import dlrs_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlrs_front.sv =====
// ----------------------------------------------------------------------------
// dlrs_front: item intake and classification
// Drops unused codes and out-of-range loads, numbers the input elements.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrs_front #(
  parameter int OUT_NODES = 16,
  parameter int IN_NODES  = 1024
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dlrs_pkg::in_item_t  in_item,
  input  wire                 q_full,
  output logic                push,
  output dlrs_pkg::cmd_t      push_cmd
);
  import dlrs_pkg::*;

  logic       accept;
  logic [9:0] pos;
  logic       node_ok;
  logic       row_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign node_ok  = 32'(in_item.node_index) < OUT_NODES;
  assign row_ok   = 32'(in_item.row_index) < IN_NODES;

  always_comb begin
    push            = 1'b0;
    push_cmd.kind   = CMD_ELEM;
    push_cmd.row    = in_item.row_index;
    push_cmd.node   = in_item.node_index;
    push_cmd.value  = in_item.value;
    push_cmd.last   = in_item.last_element;
    push_cmd.pos_ok = 32'(pos) < IN_NODES;
    unique case (in_item.op)
      OP_WEIGHT: begin
        push_cmd.kind = CMD_WEIGHT;
        push          = accept && row_ok && node_ok;
      end
      OP_BIAS: begin
        push_cmd.kind = CMD_BIAS;
        push          = accept && node_ok;
      end
      OP_ELEM: begin
        push_cmd.row = pos;
        push         = accept;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept && in_item.op == OP_ELEM) begin
      pos <= in_item.last_element ? 10'd0 : pos + 10'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlrs_back.sv =====
// ----------------------------------------------------------------------------
// dlrs_back: execution engine
// Weight memory, shared multiply-accumulate, activation and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrs_back #(
  parameter int OUT_NODES = 16,
  parameter int IN_NODES  = 1024
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_empty,
  input  dlrs_pkg::cmd_t      cmd,
  output logic                pop,
  input  wire  [1:0]          activation_mode,
  input  wire                 add_bias,
  output logic                out_valid,
  input  wire                 out_stall,
  output dlrs_pkg::out_item_t out_item
);
  import dlrs_pkg::*;

  localparam int NW = (OUT_NODES > 1) ? $clog2(OUT_NODES) : 1;
  localparam int WD = IN_NODES * OUT_NODES;
  localparam int AW = (WD > 1) ? $clog2(WD) : 1;
  localparam int DW = EXP_W + NW;
  localparam logic [NW-1:0] LAST_NODE = NW'(OUT_NODES - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_ELEM  = 12'b000000000010,
    S_DRAIN = 12'b000000000100,
    S_BIAS  = 12'b000000001000,
    S_RELU  = 12'b000000010000,
    S_MAX   = 12'b000000100000,
    S_EXPO  = 12'b000001000000,
    S_SUM   = 12'b000010000000,
    S_DIVL  = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_SMOUT = 12'b010000000000,
    S_ERR   = 12'b100000000000
  } state_t;

  state_t                    state;
  logic [NW-1:0]             c;
  logic                      c_end;
  logic signed [15:0]        wmem [WD];
  logic signed [15:0]        wdata;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic signed [ACC_W-1:0]   acc [OUT_NODES];
  logic signed [15:0]        bias [OUT_NODES];
  logic signed [15:0]        elem_val;
  logic [9:0]                elem_pos;
  logic                      elem_last;
  logic                      s1_valid;
  logic [NW-1:0]             s1_node;
  logic                      s2_valid;
  logic [NW-1:0]             s2_node;
  logic signed [31:0]        prod;
  logic signed [ACC_W-1:0]   m;
  logic [DW-1:0]             denom;
  logic [DW-1:0]             rem;
  logic [15:0]               num_lo;
  logic [15:0]               q;
  logic [3:0]                step;
  logic                      out_free;
  logic                      clear_all;

  // Per-phase datapath values.
  logic signed [ACC_W-1:0]   acc_c;
  logic signed [ACC_W-1:0]   biased;
  logic signed [ACC_W:0]     relu_sum;
  logic [ACC_W-12:0]         relu_q;
  logic signed [15:0]        relu_val;
  logic [ACC_W:0]            m_diff;
  logic [ACC_W+1:0]          idx_full;
  logic [EXP_W-1:0]          e_val;
  logic [DW+15:0]            num;
  logic [DW:0]               trial;
  logic signed [15:0]        sm_val;

  assign c_end    = (c == LAST_NODE);
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !q_empty;
  assign we       = pop && cmd.kind == CMD_WEIGHT;
  assign waddr    = AW'(cmd.row) * AW'(OUT_NODES) + AW'(cmd.node);
  assign raddr    = AW'(elem_pos) * AW'(OUT_NODES) + AW'(c);
  assign acc_c    = acc[c];

  always_comb begin
    biased   = sat40(41'(acc_c) + (add_bias ? 41'(bias[c]) <<< 12 : 41'sd0));
    relu_sum = 41'(acc_c) + 41'sd2048;
    relu_q   = relu_sum[ACC_W:12];
    if (acc_c <= 0) begin
      relu_val = 16'sd0;
    end else if (relu_q > (ACC_W-11)'(32767)) begin
      relu_val = 16'sd32767;
    end else begin
      relu_val = 16'(relu_q);
    end
    m_diff   = 41'(m) - 41'(acc_c);
    idx_full = {1'b0, m_diff} + 42'd32768;
    e_val    = (idx_full[ACC_W+1:16] < (ACC_W-14)'(EXP_DEPTH)) ?
               EXP_TAB[idx_full[EXP_LD+15:16]] : '0;
    num      = {acc_c[EXP_W-1:0], 15'd0} + (DW+16)'(denom >> 1);
    trial    = {rem, num_lo[15]};
    sm_val   = q[15] ? 16'sd32767 : 16'(q);
  end

  // Weight memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      wmem[waddr] <= cmd.value;
    end
    wdata <= wmem[raddr];
  end

  always_ff @(posedge clk) begin
    prod <= elem_val * wdata;
    if (pop && cmd.kind == CMD_BIAS) begin
      bias[cmd.node[NW-1:0]] <= cmd.value;
    end
  end

  assign clear_all = out_free && c_end &&
                     ((state == S_RELU) || (state == S_SMOUT)) ||
                     (out_free && state == S_ERR);

  // Accumulators: multiply-accumulate writes, phase rewrites, end-of-run clear.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      for (int i = 0; i < OUT_NODES; i++) begin
        acc[i] <= '0;
      end
    end else if (s2_valid) begin
      acc[s2_node] <= sat40(41'(acc[s2_node]) + 41'(prod));
    end else if (state == S_BIAS) begin
      acc[c] <= biased;
    end else if (state == S_EXPO) begin
      acc[c] <= ACC_W'(e_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      c         <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_ELEM);
      s1_node  <= c;
      s2_valid <= s1_valid;
      s2_node  <= s1_node;
      if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && cmd.kind == CMD_ELEM) begin
            elem_val  <= cmd.value;
            elem_pos  <= cmd.row;
            elem_last <= cmd.last;
            c         <= '0;
            if (cmd.pos_ok) begin
              state <= S_ELEM;
            end else if (cmd.last) begin
              state <= S_DRAIN;
            end
          end
        end
        S_ELEM: begin
          c <= c + 1'b1;
          if (c_end) begin
            state <= elem_last ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          c <= '0;
          if (!s1_valid && !s2_valid && state != S_ELEM) begin
            state <= (activation_mode == MODE_RELU || activation_mode == MODE_SOFTMAX) ?
                     S_BIAS : S_ERR;
          end
        end
        S_BIAS: begin
          c <= c + 1'b1;
          if (c_end) begin
            c     <= '0;
            state <= (activation_mode == MODE_RELU) ? S_RELU : S_MAX;
          end
        end
        S_RELU: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_item.out_node  <= 4'(c);
            out_item.out_value <= relu_val;
            out_item.out_last  <= c_end;
            out_item.status    <= 1'b0;
            c                  <= c + 1'b1;
            if (c_end) begin
              c     <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_MAX: begin
          if (c == '0 || acc_c > m) begin
            m <= acc_c;
          end
          c <= c + 1'b1;
          if (c_end) begin
            c     <= '0;
            state <= S_EXPO;
          end
        end
        S_EXPO: begin
          c     <= c + 1'b1;
          denom <= '0;
          if (c_end) begin
            c     <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          denom <= denom + DW'(acc_c);
          c     <= c + 1'b1;
          if (c_end) begin
            c     <= '0;
            state <= S_DIVL;
          end
        end
        S_DIVL: begin
          rem    <= num[DW+15:16];
          num_lo <= num[15:0];
          step   <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          // One restoring division step per cycle.
          if (trial >= {1'b0, denom}) begin
            rem <= DW'(trial - {1'b0, denom});
            q   <= {q[14:0], 1'b1};
          end else begin
            rem <= trial[DW-1:0];
            q   <= {q[14:0], 1'b0};
          end
          num_lo <= {num_lo[14:0], 1'b0};
          step   <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_SMOUT;
          end
        end
        S_SMOUT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_item.out_node  <= 4'(c);
            out_item.out_value <= sm_val;
            out_item.out_last  <= c_end;
            out_item.status    <= 1'b0;
            c                  <= c + 1'b1;
            state              <= S_DIVL;
            if (c_end) begin
              c     <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_item.out_node  <= 4'd0;
            out_item.out_value <= 16'sd0;
            out_item.out_last  <= 1'b1;
            out_item.status    <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dense_layer_relu_softmax.sv =====
// ----------------------------------------------------------------------------
// dense_layer_relu_softmax: fully connected layer with ReLU or softmax
// Loads weights and biases, accumulates streamed elements, emits one result
// per node at the end of each input vector, or one error result for an unsupported mode.
// ----------------------------------------------------------------------------
// A weight or bias load is taken by the back end in its idle state; an input
//   element is taken, then passes the MAC once per node before the next command.
// After the last element the back drains the MAC pipeline and applies the biases
//   if enabled; ReLU then emits one result per cycle while the output is not stalled,
//   and softmax passes max, exp and sum, then runs the 16-step division per result.
// Reset (rst, synchronous) clears control and accumulators and sets ReLU with bias.
`default_nettype none

module dense_layer_relu_softmax #(
  parameter int OUT_NODES = 16,
  parameter int IN_NODES  = 1024
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dlrs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output dlrs_pkg::out_item_t out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [1:0]          cfg_data
);
  import dlrs_pkg::*;

  // Configuration registers. Writes arrive only while the block is idle: the user is bound
  // to this and the block itself does not enforce it; writes are always taken.
  logic [1:0] activation_mode;
  logic       add_bias;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      activation_mode <= MODE_RELU;
      add_bias        <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MODE) begin
        activation_mode <= cfg_data;
      end else if (cfg_index == CFG_BIAS) begin
        add_bias <= cfg_data[0];
      end
    end
  end

  // The front classifies items into commands; the queue lets the front keep
  // taking loads while the back is busy with an element or an activation.
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t pop_cmd;

  dlrs_front #(
    .OUT_NODES (OUT_NODES),
    .IN_NODES  (IN_NODES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dlrs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // The back owns the weight memory, the accumulators and the output register,
  // which lets it go on with a division or a command while a result waits to be taken.
  dlrs_back #(
    .OUT_NODES (OUT_NODES),
    .IN_NODES  (IN_NODES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .cmd             (pop_cmd),
    .pop             (pop),
    .activation_mode (activation_mode),
    .add_bias        (add_bias),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item)
  );

  // Both activations produce values that are never negative.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_item.out_value[15])
    else $error("negative activation result");

  // An error result is a lone, marked result for node zero with value zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |->
      out_item.out_last && out_item.out_node == 4'd0 && out_item.out_value == 16'sd0)
    else $error("malformed error result");

  // A normal run ends on the highest node.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_last && !out_item.status |->
      out_item.out_node == 4'(OUT_NODES - 1))
    else $error("run ended on wrong node");

endmodule

`default_nettype wire
